/* rtl/prs_pkg.sv */
`timescale 1ns / 1ps
package prs_pkg;

	localparam int VFRAC       = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int VEC_W       = 33;
	localparam int UNIT_W      = 26;
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;

	localparam logic [40:0] POW_ONE = 41'(1) << VFRAC;
	localparam logic [40:0] POW_CAP = 41'(1) << 40;
	localparam logic [40:0] ACC_ONE = 41'(1) << 40;

	typedef enum logic [2:0] {
		REG_AMBIENT,
		REG_DIFFUSE,
		REG_SPECULAR,
		REG_LIGHT_X,
		REG_LIGHT_Y,
		REG_LIGHT_Z,
		REG_CAMERA,
		REG_SHININESS
	} reg_idx_t;

	typedef enum logic [3:0] {
		UV_IDLE,
		UV_MAX,
		UV_NORM,
		UV_SQ,
		UV_SUM,
		UV_SQRT,
		UV_DIV,
		UV_DONE
	} uv_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_VEC,
		BK_DOT,
		BK_D,
		BK_R1,
		BK_R2,
		BK_RE1,
		BK_RE2,
		BK_POWLO,
		BK_POWHI,
		BK_COL1,
		BK_COL2,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	typedef struct packed {
		logic [47:0] ambient;
		logic [47:0] diffuse;
		logic [47:0] specular;
		logic [31:0] light_x;
		logic [31:0] light_y;
		logic [31:0] light_z;
		logic [30:0] camera;
		logic [7:0]  shininess;
	} cfg_t;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] lv;
		logic [2:0][VEC_W-1:0] ev;
		logic [2:0][15:0]      nrm;
	} item_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctl_t;

endpackage

/* rtl/phong_reflectance_shader_top.sv */
`timescale 1ns / 1ps
// Phong shader: an item (surface point and normal) is taken while busy is low and goes
// into a four-entry queue, so a burst of items is accepted one per clock until the queue
// fills. The shading engine works on one item at a time. Normalizing the light and eye
// vectors uses a bit-serial square root and divides, after shifts that scale each
// vector by its largest component; a zero vector skips these steps. The dot products,
// color sums and queue handoff follow, and the specular power repeats the BK_POWLO and
// BK_POWHI states once per unit of shininess. Each result is shown for exactly one
// cycle with valid high and must be taken then.
module phong_reflectance_shader_top #(
	parameter int QUEUE_DEPTH = prs_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  prs_pkg::pixel_t             pixel,
	output logic                        valid,
	output prs_pkg::color_t             color,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [prs_pkg::ADDR_W-1:0]  paddr,
	input  logic [prs_pkg::DATA_W-1:0]  pwdata,
	output logic [prs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import prs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;
	q_ctl_t   qctl;
	item_t    q_item;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{shininess: 8'd1, default: '0};
		end else if (wr) begin
			unique case (idx)
				REG_AMBIENT:   cfg_q.ambient   <= pwdata[47:0];
				REG_DIFFUSE:   cfg_q.diffuse   <= pwdata[47:0];
				REG_SPECULAR:  cfg_q.specular  <= pwdata[47:0];
				REG_LIGHT_X:   cfg_q.light_x   <= pwdata[31:0];
				REG_LIGHT_Y:   cfg_q.light_y   <= pwdata[31:0];
				REG_LIGHT_Z:   cfg_q.light_z   <= pwdata[31:0];
				REG_CAMERA:    cfg_q.camera    <= pwdata[30:0];
				REG_SHININESS: cfg_q.shininess <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_AMBIENT:   prdata = DATA_W'(cfg_q.ambient);
			REG_DIFFUSE:   prdata = DATA_W'(cfg_q.diffuse);
			REG_SPECULAR:  prdata = DATA_W'(cfg_q.specular);
			REG_LIGHT_X:   prdata = DATA_W'(cfg_q.light_x);
			REG_LIGHT_Y:   prdata = DATA_W'(cfg_q.light_y);
			REG_LIGHT_Z:   prdata = DATA_W'(cfg_q.light_z);
			REG_CAMERA:    prdata = DATA_W'(cfg_q.camera);
			REG_SHININESS: prdata = DATA_W'(cfg_q.shininess);
			default:       prdata = '0;
		endcase
	end

	prs_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.pixel   (pixel),
		.cfg     (cfg_q),
		.pop     (qctl.pop),
		.q_valid (qctl.valid),
		.q_item  (q_item)
	);

	prs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (qctl.valid),
		.q_item  (q_item),
		.pop     (qctl.pop),
		.valid   (valid),
		.color   (color)
	);

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result strobe held two cycles");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.pop |-> qctl.valid)
		else $error("pop from empty queue");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted item");

endmodule

/* rtl/prs_front.sv */
`timescale 1ns / 1ps
module prs_front #(
	parameter int DEPTH = prs_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  prs_pkg::pixel_t pixel,
	input  prs_pkg::cfg_t   cfg,
	input  logic            pop,
	output logic            q_valid,
	output prs_pkg::item_t  q_item
);
	import prs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          fifo_q [DEPTH];
	logic [PW-1:0]  head_q, tail_q;
	logic [CW-1:0]  count_q;
	item_t          entry;
	logic           push;

	assign push    = start && !busy;
	assign busy    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = fifo_q[head_q];

	always_comb begin
		entry        = '0;
		entry.lv[0]  = {cfg.light_x[31], cfg.light_x} - {pixel.point_x[31], pixel.point_x};
		entry.lv[1]  = {cfg.light_y[31], cfg.light_y} - {pixel.point_y[31], pixel.point_y};
		entry.lv[2]  = {cfg.light_z[31], cfg.light_z} - {pixel.point_z[31], pixel.point_z};
		entry.ev[0]  = VEC_W'(0) - {pixel.point_x[31], pixel.point_x};
		entry.ev[1]  = VEC_W'(0) - {pixel.point_y[31], pixel.point_y};
		entry.ev[2]  = VEC_W'(0) - {2'b00, cfg.camera} - {pixel.point_z[31], pixel.point_z};
		entry.nrm[0] = pixel.normal_x;
		entry.nrm[1] = pixel.normal_y;
		entry.nrm[2] = pixel.normal_z;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[tail_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/prs_unitvec.sv */
`timescale 1ns / 1ps
module prs_unitvec (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [2:0][prs_pkg::VEC_W-1:0]       vec,
	output logic                                 done,
	output logic [2:0][prs_pkg::UNIT_W-1:0]      unit
);
	import prs_pkg::*;

	uv_state_t             state_q, state_d;
	logic [2:0][VEC_W-1:0] mag_q;
	logic [2:0]            neg_q;
	logic [VEC_W-1:0]      max_q, max_d, m01;
	logic [2:0][59:0]      sq_q;
	logic [61:0]           rem_q, root_q, bit_q;
	logic [62:0]           sq_sum;
	logic                  sq_ge;
	logic [4:0]            cnt_q;
	logic [2:0][30:0]      drem_q;
	logic [2:0][24:0]      quo_q;
	logic [2:0][31:0]      dtrial;
	logic [2:0]            dge;
	logic [30:0]           len;
	logic                  shr, shl;

	assign m01    = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign max_d  = (m01 > mag_q[2]) ? m01 : mag_q[2];
	assign shr    = |max_q[VEC_W-1:30];
	assign shl    = ~|max_q[VEC_W-1:29];
	assign sq_sum = {1'b0, root_q} + {1'b0, bit_q};
	assign sq_ge  = ({1'b0, rem_q} >= sq_sum);
	assign len    = root_q[30:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dtrial[k] = {drem_q[k], (cnt_q == 5'd24) & mag_q[k][0]};
			dge[k]    = (dtrial[k] >= {1'b0, len});
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			UV_IDLE, UV_DONE: if (start) state_d = UV_MAX;
			UV_MAX:           state_d = (max_d == '0) ? UV_DONE : UV_NORM;
			UV_NORM:          if (!shr && !shl) state_d = UV_SQ;
			UV_SQ:            state_d = UV_SUM;
			UV_SUM:           state_d = UV_SQRT;
			UV_SQRT:          if (bit_q == 62'd1) state_d = UV_DIV;
			UV_DIV:           if (cnt_q == '0) state_d = UV_DONE;
			default:          state_d = UV_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == UV_DONE);
		for (int k = 0; k < 3; k++) begin
			unit[k] = neg_q[k] ? UNIT_W'(0) - {1'b0, quo_q[k]} : {1'b0, quo_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			UV_IDLE, UV_DONE: begin
				if (start) begin
					for (int k = 0; k < 3; k++) begin
						neg_q[k] <= vec[k][VEC_W-1];
						mag_q[k] <= vec[k][VEC_W-1] ? VEC_W'(0) - vec[k] : vec[k];
					end
				end
			end
			UV_MAX: begin
				max_q <= max_d;
				for (int k = 0; k < 3; k++) begin
					quo_q[k] <= '0;
				end
			end
			UV_NORM: begin
				if (shr) begin
					max_q <= max_q >> 1;
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end else if (shl) begin
					max_q <= max_q << 1;
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] << 1;
					end
				end
			end
			UV_SQ: begin
				for (int k = 0; k < 3; k++) begin
					sq_q[k] <= mag_q[k][29:0] * mag_q[k][29:0];
				end
			end
			UV_SUM: begin
				rem_q  <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
				root_q <= '0;
				bit_q  <= 62'(1) << 60;
				cnt_q  <= 5'd24;
				for (int k = 0; k < 3; k++) begin
					drem_q[k] <= 31'(mag_q[k][29:1]);
				end
			end
			UV_SQRT: begin
				if (sq_ge) begin
					rem_q  <= rem_q - sq_sum[61:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			UV_DIV: begin
				for (int k = 0; k < 3; k++) begin
					if (dge[k]) begin
						drem_q[k] <= 31'(dtrial[k] - {1'b0, len});
						quo_q[k]  <= {quo_q[k][23:0], 1'b1};
					end else begin
						drem_q[k] <= dtrial[k][30:0];
						quo_q[k]  <= {quo_q[k][23:0], 1'b0};
					end
				end
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/prs_back.sv */
`timescale 1ns / 1ps
module prs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  prs_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  prs_pkg::item_t  q_item,
	output logic            pop,
	output logic            valid,
	output prs_pkg::color_t color
);
	import prs_pkg::*;

	bk_state_t              state_q, state_d;
	logic                   l_done, e_done;
	logic [2:0][UNIT_W-1:0] l_u, e_u;
	logic [2:0][15:0]       nrm_q;

	logic signed [41:0] pn      [3];
	logic signed [41:0] pn_q    [3];
	logic signed [43:0] dot_sum;
	logic signed [29:0] d_q;
	logic signed [45:0] dn      [3];
	logic signed [45:0] dn_q    [3];
	logic signed [32:0] rt      [3];
	logic signed [31:0] r_q     [3];
	logic signed [57:0] rep     [3];
	logic signed [57:0] rep_q   [3];
	logic signed [59:0] re_sum;
	logic [31:0]        su_q;
	logic [40:0]        pw_q;
	logic [7:0]         exp_q;
	logic [56:0]        plo, phi, plo_q;
	logic [72:0]        prod;
	logic [48:0]        pnext;
	logic               dpos;
	logic [42:0]        dterm   [3];
	logic [42:0]        dterm_q [3];
	logic [56:0]        sterm   [3];
	logic [56:0]        sterm_q [3];
	logic [57:0]        acc     [3];
	logic [40:0]        acc_q   [3];
	logic [48:0]        scaled  [3];
	logic [2:0][7:0]    chan;
	color_t             color_q;
	logic               valid_q;

	prs_unitvec u_light (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pop),
		.vec    (q_item.lv),
		.done   (l_done),
		.unit   (l_u)
	);

	prs_unitvec u_eye (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pop),
		.vec    (q_item.ev),
		.done   (e_done),
		.unit   (e_u)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pn[k]    = $signed(nrm_q[k]) * $signed(l_u[k]);
			dn[k]    = d_q * $signed(nrm_q[k]);
			rt[k]    = $signed(dn_q[k][45:13]) - $signed(l_u[k]);
			rep[k]   = r_q[k] * $signed(e_u[k]);
			dterm[k] = dpos ? d_q[26:0] * cfg.diffuse[47-16*k -: 16] : '0;
			sterm[k] = pw_q * cfg.specular[47-16*k -: 16];
			acc[k]   = {18'b0, cfg.ambient[47-16*k -: 16], 24'b0} + 58'(dterm_q[k])
				+ 58'(sterm_q[k]);
			scaled[k] = {acc_q[k], 8'b0} - 49'(acc_q[k]) + (49'(1) << 39);
			chan[k]   = scaled[k][47:40];
		end
		dot_sum = pn_q[0] + pn_q[1] + pn_q[2];
		re_sum  = rep_q[0] + rep_q[1] + rep_q[2];
		dpos    = !d_q[29] && (d_q != '0);
		plo     = pw_q * su_q[15:0];
		phi     = pw_q * su_q[31:16];
		prod    = {phi, 16'b0} + 73'(plo_q);
		pnext   = prod[72:24];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_VEC;
			BK_VEC:   if (l_done && e_done) state_d = BK_DOT;
			BK_DOT:   state_d = BK_D;
			BK_D:     state_d = BK_R1;
			BK_R1:    state_d = BK_R2;
			BK_R2:    state_d = BK_RE1;
			BK_RE1:   state_d = BK_RE2;
			BK_RE2:   state_d = (cfg.shininess == '0) ? BK_COL1 : BK_POWLO;
			BK_POWLO: state_d = BK_POWHI;
			BK_POWHI: state_d = (exp_q == 8'd1) ? BK_COL1 : BK_POWLO;
			BK_COL1:  state_d = BK_COL2;
			BK_COL2:  state_d = BK_OUT;
			BK_OUT:   state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == BK_IDLE) && q_valid;
		valid = valid_q;
		color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == BK_OUT);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: if (q_valid) nrm_q <= q_item.nrm;
			BK_DOT: begin
				for (int k = 0; k < 3; k++) pn_q[k] <= pn[k];
			end
			BK_D: d_q <= dot_sum[43:14];
			BK_R1: begin
				for (int k = 0; k < 3; k++) dn_q[k] <= dn[k];
			end
			BK_R2: begin
				for (int k = 0; k < 3; k++) r_q[k] <= rt[k][31:0];
			end
			BK_RE1: begin
				for (int k = 0; k < 3; k++) rep_q[k] <= rep[k];
			end
			BK_RE2: begin
				su_q  <= re_sum[59] ? '0 : re_sum[55:24];
				pw_q  <= POW_ONE;
				exp_q <= cfg.shininess;
			end
			BK_POWLO: plo_q <= plo;
			BK_POWHI: begin
				pw_q  <= (pnext > 49'(POW_CAP)) ? POW_CAP : pnext[40:0];
				exp_q <= exp_q - 1'b1;
			end
			BK_COL1: begin
				for (int k = 0; k < 3; k++) begin
					dterm_q[k] <= dterm[k];
					sterm_q[k] <= sterm[k];
				end
			end
			BK_COL2: begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= (acc[k] > 58'(ACC_ONE)) ? ACC_ONE : acc[k][40:0];
				end
			end
			BK_OUT: begin
				color_q.red   <= chan[0];
				color_q.green <= chan[1];
				color_q.blue  <= chan[2];
			end
			default: ;
		endcase
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import prs_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		pixel_t px;
		bit     typed;
		color_t want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	pixel_t              pixel;
	logic                valid;
	color_t              color;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	cfg_t      shade_cfg;
	color_t    pending_colors[$];
	stim_row_t rows[$];
	int        errors;
	int        burst_left;
	int        quiet_cycles;

	phong_reflectance_shader_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.valid(valid), .color(color), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void normalize(input longint c[3], output longint u[3]);
		longint unsigned a[3];
		longint unsigned m;
		longint unsigned len;
		longint unsigned q;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
			if (a[i] > m) m = a[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) a[i] >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) a[i] <<= 1;
			m <<= 1;
		end
		len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] << VFRAC) / len;
			u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic color_t shade(pixel_t px);
		longint pt[3];
		longint nv[3];
		longint lv[3];
		longint ev[3];
		longint l[3];
		longint e[3];
		longint r[3];
		longint d;
		longint re;
		longint unsigned su;
		longint unsigned pw;
		longint unsigned acc;
		longint unsigned ac;
		longint unsigned dc;
		longint unsigned sc;
		logic [127:0] prod;
		logic [7:0] ch[3];
		color_t c;
		pt[0] = px.point_x;
		pt[1] = px.point_y;
		pt[2] = px.point_z;
		nv[0] = px.normal_x;
		nv[1] = px.normal_y;
		nv[2] = px.normal_z;
		lv[0] = longint'(signed'(shade_cfg.light_x)) - pt[0];
		lv[1] = longint'(signed'(shade_cfg.light_y)) - pt[1];
		lv[2] = longint'(signed'(shade_cfg.light_z)) - pt[2];
		ev[0] = -pt[0];
		ev[1] = -pt[1];
		ev[2] = -longint'({33'd0, shade_cfg.camera}) - pt[2];
		normalize(lv, l);
		normalize(ev, e);
		d = (nv[0] * l[0] + nv[1] * l[1] + nv[2] * l[2]) >>> 14;
		for (int k = 0; k < 3; k++) r[k] = ((2 * d * nv[k]) >>> 14) - l[k];
		re = (r[0] * e[0] + r[1] * e[1] + r[2] * e[2]) >>> VFRAC;
		su = re < 0 ? 0 : re;
		pw = 64'd1 << VFRAC;
		for (int i = 0; i < shade_cfg.shininess; i++) begin
			prod = (128'(pw) * 128'(su)) >> VFRAC;
			pw = prod > 128'(POW_CAP) ? 64'(POW_CAP) : 64'(prod);
		end
		for (int k = 0; k < 3; k++) begin
			ac = (shade_cfg.ambient >> (32 - 16 * k)) & 64'hFFFF;
			dc = (shade_cfg.diffuse >> (32 - 16 * k)) & 64'hFFFF;
			sc = (shade_cfg.specular >> (32 - 16 * k)) & 64'hFFFF;
			acc = ac << VFRAC;
			if (d > 0) acc += longint'(d) * dc;
			acc += pw * sc;
			if (acc > 64'(ACC_ONE)) acc = ACC_ONE;
			ch[k] = 8'((255 * acc + (64'd1 << 39)) >> 40);
		end
		c.red = ch[0];
		c.green = ch[1];
		c.blue = ch[2];
		return c;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(8 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AMBIENT:   shade_cfg.ambient = value[47:0];
			REG_DIFFUSE:   shade_cfg.diffuse = value[47:0];
			REG_SPECULAR:  shade_cfg.specular = value[47:0];
			REG_LIGHT_X:   shade_cfg.light_x = value[31:0];
			REG_LIGHT_Y:   shade_cfg.light_y = value[31:0];
			REG_LIGHT_Z:   shade_cfg.light_z = value[31:0];
			REG_CAMERA:    shade_cfg.camera = value[30:0];
			REG_SHININESS: shade_cfg.shininess = value[7:0];
			default: ;
		endcase
	endtask

	task automatic load_cfg(cfg_t c);
		wait (pending_colors.size() == 0);
		repeat (20) @(posedge clk);
		write_reg(REG_AMBIENT, 64'(c.ambient));
		write_reg(REG_DIFFUSE, 64'(c.diffuse));
		write_reg(REG_SPECULAR, 64'(c.specular));
		write_reg(REG_LIGHT_X, 64'(c.light_x));
		write_reg(REG_LIGHT_Y, 64'(c.light_y));
		write_reg(REG_LIGHT_Z, 64'(c.light_z));
		write_reg(REG_CAMERA, 64'(c.camera));
		write_reg(REG_SHININESS, 64'(c.shininess));
	endtask

	task automatic send_item(pixel_t px, bit typed, color_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		start <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (busy !== 1'b0);
		pending_colors.push_back(typed ? want : shade(px));
		burst_left--;
	endtask

	function automatic pixel_t make_pixel(longint x, longint y, longint z,
			int nx, int ny, int nz);
		pixel_t p;
		p.point_x = 32'(x);
		p.point_y = 32'(y);
		p.point_z = 32'(z);
		p.normal_x = 16'(nx);
		p.normal_y = 16'(ny);
		p.normal_z = 16'(nz);
		return p;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		real vx;
		real vy;
		real vz;
		real mag;
		if ($urandom_range(0, 4) == 0) begin
			p = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
			return p;
		end
		p.point_x = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
		p.point_y = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
		p.point_z = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
		do begin
			vx = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			vy = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			vz = $itor($signed($urandom_range(0, 2000))) - 1000.0;
			mag = $sqrt(vx * vx + vy * vy + vz * vz);
		end while (mag < 1.0);
		p.normal_x = 16'($rtoi(vx * 16384.0 / mag));
		p.normal_y = 16'($rtoi(vy * 16384.0 / mag));
		p.normal_z = 16'($rtoi(vz * 16384.0 / mag));
		return p;
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.ambient = {16'($urandom_range(0, 16'h4000)), 16'($urandom_range(0, 16'h4000)),
			16'($urandom_range(0, 16'h4000))};
		c.diffuse = {16'($urandom), 16'($urandom), 16'($urandom)};
		c.specular = {16'($urandom), 16'($urandom), 16'($urandom)};
		c.light_x = $signed($urandom_range(0, 2 ** 23)) - 2 ** 22;
		c.light_y = $signed($urandom_range(0, 2 ** 23)) - 2 ** 22;
		c.light_z = -$signed($urandom_range(0, 2 ** 23));
		c.camera = 31'($urandom_range(0, 2 ** 23));
		c.shininess = 8'($urandom_range(0, 40));
		return c;
	endfunction

	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected color %h", $time, color);
				errors++;
			end else begin
				if (color.red !== pending_colors[0].red)
					$display("%0t: red expected %0d actual %0d", $time,
						pending_colors[0].red, color.red);
				if (color.green !== pending_colors[0].green)
					$display("%0t: green expected %0d actual %0d", $time,
						pending_colors[0].green, color.green);
				if (color.blue !== pending_colors[0].blue)
					$display("%0t: blue expected %0d actual %0d", $time,
						pending_colors[0].blue, color.blue);
				if (color !== pending_colors[0]) errors++;
				void'(pending_colors.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || valid || (start && busy === 1'b0) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		cfg_t c;
		color_t none;
		none = '0;
		errors = 0;
		burst_left = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		shade_cfg = '0;
		shade_cfg.shininess = 8'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back('{make_pixel(0, 0, 0, 0, 0, 0), 1'b1, none});
		rows.push_back('{make_pixel(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32767, 32767, 32767), 1'b1, none});
		rows.push_back('{make_pixel(-64'sh80000000, -64'sh80000000, -64'sh80000000,
			-32768, -32768, -32768), 1'b1, none});
		rows.push_back('{make_pixel(-1, -1, -1, -1, -1, -1), 1'b1, none});
		rows.push_back('{make_pixel(0, 0, 0, 0, 0, -16384), 1'b0, none});
		rows.push_back('{make_pixel(0, 0, -10 <<< 16, 0, 0, -16384), 1'b0, none});
		rows.push_back('{make_pixel(0, 0, -5 <<< 16, 0, 0, -16384), 1'b0, none});
		rows.push_back('{make_pixel(0, 0, 0, 0, 0, 16384), 1'b0, none});
		rows.push_back('{make_pixel(0, 0, 0, 0, 0, -32768), 1'b0, none});
		rows.push_back('{make_pixel(0, 0, 0, 32767, 32767, 32767), 1'b0, none});
		rows.push_back('{make_pixel(1 <<< 16, 2 <<< 16, 0, 0, 11585, -11585), 1'b0, none});
		rows.push_back('{make_pixel(32'h7FFFFFFF, -64'sh80000000, 32'h7FFFFFFF,
			-32768, 32767, -32768), 1'b0, none});
		rows.push_back('{make_pixel(-64'sh80000000, 32'h7FFFFFFF, -64'sh80000000,
			16384, 0, 0), 1'b0, none});
		rows.push_back('{make_pixel(3 <<< 16, -2 <<< 16, 4 <<< 16, 5000, -6000, -14000),
			1'b0, none});

		foreach (rows[i]) begin
			if (i == 4) begin
				c.ambient = 48'h1000_2000_3000;
				c.diffuse = 48'h8000_8000_8000;
				c.specular = 48'hFFFF_8000_4000;
				c.light_x = 32'd0;
				c.light_y = 32'd0;
				c.light_z = 32'(-10 <<< 16);
				c.camera = 31'(5 <<< 16);
				c.shininess = 8'd8;
				start <= 1'b0;
				burst_left = 0;
				load_cfg(c);
			end
			if (i == 10) begin
				start <= 1'b0;
				burst_left = 0;
				wait (pending_colors.size() == 0);
				repeat (20) @(posedge clk);
				write_reg(REG_SHININESS, 64'd0);
			end
			send_item(rows[i].px, rows[i].typed, rows[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			c = random_cfg();
			if (ph == 1) begin
				c.ambient = '1;
				c.diffuse = '1;
				c.specular = '1;
				c.light_x = 32'h7FFFFFFF;
				c.light_y = 32'h80000000;
				c.light_z = 32'h80000000;
				c.camera = '1;
				c.shininess = 8'd255;
			end else if (ph == 2) begin
				c.ambient = '0;
				c.diffuse = '1;
				c.specular = '1;
				c.light_x = 32'h80000000;
				c.light_y = 32'h7FFFFFFF;
				c.light_z = 32'h7FFFFFFF;
				c.camera = '0;
				c.shininess = 8'd0;
			end
			start <= 1'b0;
			burst_left = 0;
			load_cfg(c);
			for (int n = 0; n < (ph == 1 ? 60 : 240); n++)
				send_item(random_pixel(), 1'b0, none);
		end
		start <= 1'b0;
		wait (pending_colors.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
